[rtl/core/mct_pkg.sv]
// shared types and constants for the multiset count table
package mct_pkg;

    localparam int COUNT_W  = 31;
    localparam int IN_W     = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEG  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_UPD
    } state_t;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_CMP,
        CELL_WRITE,
        CELL_LOAD,
        CELL_SHIFT
    } cell_op_t;

endpackage

[rtl/core/mct_cell.sv]
// one table entry: value, count and match flag, shifts down from its upper neighbor
module mct_cell #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX       = 0
) (
    input  logic                                aclk,
    input  mct_pkg::cell_op_t                   op,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      slot,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    used,
    input  logic [VALUE_WIDTH-1:0]              value_in,
    input  logic [mct_pkg::COUNT_W-1:0]         count_in,
    input  logic [VALUE_WIDTH-1:0]              nb_value,
    input  logic [mct_pkg::COUNT_W-1:0]         nb_count,
    output logic [VALUE_WIDTH-1:0]              value_out,
    output logic [mct_pkg::COUNT_W-1:0]         count_out,
    output logic                                hit
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

    logic [VALUE_WIDTH-1:0]      value_reg;
    logic [mct_pkg::COUNT_W-1:0] count_reg;
    logic                        hit_reg;

    always_ff @(posedge aclk) begin
        case (op)
            mct_pkg::CELL_CMP: begin
                hit_reg <= (MY_POS < used) && (value_reg == value_in);
            end
            mct_pkg::CELL_WRITE: begin
                if (MY_IDX == slot) begin
                    count_reg <= count_in;
                end
            end
            mct_pkg::CELL_LOAD: begin
                if (MY_IDX == slot) begin
                    value_reg <= value_in;
                    count_reg <= count_in;
                end
            end
            mct_pkg::CELL_SHIFT: begin
                if (MY_IDX >= slot) begin
                    value_reg <= nb_value;
                    count_reg <= nb_count;
                end
            end
            default: begin
            end
        endcase
    end

    assign value_out = value_reg;
    assign count_out = count_reg;
    assign hit       = hit_reg;

endmodule

[rtl/core/multiset_count_table.sv]
// multiset count table: chain of entry cells with a request sequencer
//
// s_ channel carries one request per transaction: action (0 add one,
// 1 remove up to amount, 2 or 3 query), value and amount. m_ channel
// returns one result per request: found, occurrences, removed, total,
// distinct and status.
// Each request goes from acceptance to a valid result in these steps: the
// request is registered at the accepting edge, then every cell compares its
// value, then the matching entry and its count are picked out, then the
// cells are updated and the result register is loaded. A new request is
// taken only once the previous one has reached the result register.
// If the receiver stalls, the result holds on m_ and the next request
// may be accepted and worked up to its update step, where it waits until
// the result register is free.
// Reset (aresetn low at a clock edge) empties the table: distinct and
// total return to zero and no result is pending. Entry storage is not
// cleared; only entries below the distinct count are ever looked at.
module multiset_count_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [mct_pkg::ACTION_W-1:0]            s_action,
    input  logic signed [mct_pkg::IN_W-1:0]         s_value,
    input  logic signed [mct_pkg::IN_W-1:0]         s_amount,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_found,
    output logic [mct_pkg::COUNT_W-1:0]             m_occurrences,
    output logic [mct_pkg::COUNT_W-1:0]             m_removed,
    output logic [mct_pkg::COUNT_W-1:0]             m_total,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]        m_distinct,
    output logic [mct_pkg::STATUS_W-1:0]            m_status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = mct_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    mct_pkg::state_t state_reg, state_next;

    logic [mct_pkg::ACTION_W-1:0] action_reg;
    logic [VALUE_WIDTH-1:0]       req_v_reg;
    logic [mct_pkg::IN_W-1:0]     amount_reg;
    logic                         found_reg;
    logic [IDX_W-1:0]             slot_reg;
    logic [CW-1:0]                cnt_reg;

    logic [CNT_W-1:0] used_reg, used_next;
    logic [CW-1:0]    total_reg, total_next;

    logic                          m_valid_reg;
    logic                          found_out_reg;
    logic [CW-1:0]                 occ_reg, occ_next;
    logic [CW-1:0]                 removed_reg, removed_next;
    logic [mct_pkg::STATUS_W-1:0]  status_reg, status_next;

    mct_pkg::cell_op_t cell_op;
    logic [IDX_W-1:0]  cell_slot;
    logic [CW-1:0]     cell_count;

    logic [VALUE_WIDTH-1:0] value_q [TABLE_DEPTH];
    logic [CW-1:0]          count_q [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_q;

    logic [63:0]            value_ext;
    logic                   any_hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [CW-1:0]          hit_cnt;
    logic                   upd_go;
    logic [CW-1:0]          amt31;

    assign value_ext = 64'(s_value);
    assign s_ready   = (state_reg == mct_pkg::ST_IDLE);
    assign upd_go    = (state_reg == mct_pkg::ST_UPD) && (!m_valid_reg || m_ready);
    assign amt31     = amount_reg[CW-1:0];

    // cell chain
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] nb_v;
        logic [CW-1:0]          nb_c;
        if (i == TABLE_DEPTH - 1) begin : g_last
            assign nb_v = '0;
            assign nb_c = '0;
        end else begin : g_mid
            assign nb_v = value_q[i+1];
            assign nb_c = count_q[i+1];
        end
        mct_cell #(
            .TABLE_DEPTH(TABLE_DEPTH),
            .VALUE_WIDTH(VALUE_WIDTH),
            .INDEX(i)
        ) u_cell (
            .aclk(aclk),
            .op(cell_op),
            .slot(cell_slot),
            .used(used_reg),
            .value_in(req_v_reg),
            .count_in(cell_count),
            .nb_value(nb_v),
            .nb_count(nb_c),
            .value_out(value_q[i]),
            .count_out(count_q[i]),
            .hit(hit_q[i])
        );
    end

    // match reduction
    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        hit_cnt = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            any_hit = any_hit | hit_q[i];
            hit_idx = hit_idx | (hit_q[i] ? IDX_W'(i) : '0);
            hit_cnt = hit_cnt | (hit_q[i] ? count_q[i] : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mct_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mct_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = mct_pkg::ST_CMP;
                end
            end
            mct_pkg::ST_CMP: state_next = mct_pkg::ST_SEL;
            mct_pkg::ST_SEL: state_next = mct_pkg::ST_UPD;
            mct_pkg::ST_UPD: begin
                if (upd_go) begin
                    state_next = mct_pkg::ST_IDLE;
                end
            end
            default: state_next = mct_pkg::ST_IDLE;
        endcase
    end

    // request and match registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            req_v_reg  <= value_ext[VALUE_WIDTH-1:0];
            amount_reg <= s_amount;
        end
        if (state_reg == mct_pkg::ST_SEL) begin
            found_reg <= any_hit;
            slot_reg  <= hit_idx;
            cnt_reg   <= hit_cnt;
        end
    end

    // cell operations for the compare and update steps
    always_comb begin
        cell_op      = mct_pkg::CELL_NOP;
        cell_slot    = slot_reg;
        cell_count   = '0;
        used_next    = used_reg;
        total_next   = total_reg;
        occ_next     = found_reg ? cnt_reg : '0;
        removed_next = '0;
        status_next  = mct_pkg::STATUS_OK;
        if (state_reg == mct_pkg::ST_CMP) begin
            cell_op = mct_pkg::CELL_CMP;
        end else if (upd_go) begin
            case (action_reg)
                mct_pkg::ACT_ADD: begin
                    if (found_reg) begin
                        if (cnt_reg != mct_pkg::COUNT_MAX) begin
                            cell_op    = mct_pkg::CELL_WRITE;
                            cell_count = cnt_reg + CW'(1);
                            occ_next   = cnt_reg + CW'(1);
                            if (total_reg != mct_pkg::COUNT_MAX) begin
                                total_next = total_reg + CW'(1);
                            end
                        end
                    end else if (used_reg == FULL_CNT) begin
                        status_next = mct_pkg::STATUS_FULL;
                    end else begin
                        cell_op    = mct_pkg::CELL_LOAD;
                        cell_slot  = used_reg[IDX_W-1:0];
                        cell_count = CW'(1);
                        used_next  = used_reg + CNT_W'(1);
                        occ_next   = CW'(1);
                        if (total_reg != mct_pkg::COUNT_MAX) begin
                            total_next = total_reg + CW'(1);
                        end
                    end
                end
                mct_pkg::ACT_REMOVE: begin
                    if (amount_reg[mct_pkg::IN_W-1]) begin
                        status_next = mct_pkg::STATUS_NEG;
                    end else if (found_reg) begin
                        if (cnt_reg > amt31) begin
                            cell_op      = mct_pkg::CELL_WRITE;
                            cell_count   = cnt_reg - amt31;
                            occ_next     = cnt_reg - amt31;
                            removed_next = amt31;
                        end else begin
                            cell_op      = mct_pkg::CELL_SHIFT;
                            used_next    = used_reg - CNT_W'(1);
                            occ_next     = '0;
                            removed_next = cnt_reg;
                        end
                        total_next = (total_reg > removed_next) ?
                                     (total_reg - removed_next) : '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (upd_go) begin
                used_reg    <= used_next;
                total_reg   <= total_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_go) begin
            found_out_reg <= found_reg;
            occ_reg       <= occ_next;
            removed_reg   <= removed_next;
            status_reg    <= status_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = found_out_reg;
    assign m_occurrences = occ_reg;
    assign m_removed     = removed_reg;
    assign m_total       = total_reg;
    assign m_distinct    = used_reg;
    assign m_status      = status_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// testbench for multiset_count_table: request driver, result monitor and scoreboard
module tb;

    localparam int TABLE_DEPTH  = 64;
    localparam int DIST_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RANDOM_ITEMS = 1350;
    localparam int PHASE_ITEMS  = 150;
    localparam int POOL_MAX     = 96;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [mct_pkg::ACTION_W-1:0] ACT_QUERY = 2'd2;
    localparam logic [mct_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN} phase_t;

    typedef struct {
        logic                         found;
        logic [mct_pkg::COUNT_W-1:0]  occurrences;
        logic [mct_pkg::COUNT_W-1:0]  removed;
        logic [mct_pkg::COUNT_W-1:0]  total;
        logic [DIST_W-1:0]            distinct;
        logic [mct_pkg::STATUS_W-1:0] status;
    } bag_result_t;

    class bag_scoreboard;
        logic [mct_pkg::IN_W-1:0]    slot_value [TABLE_DEPTH];
        logic [mct_pkg::COUNT_W-1:0] slot_count [TABLE_DEPTH];
        int                          used_slots = 0;
        logic [mct_pkg::COUNT_W-1:0] running_total = '0;
        bag_result_t                 pending_results [$];
        int errors = 0;
        int results_checked = 0;
        int full_drops = 0;
        int neg_rejects = 0;
        int deletions = 0;
        int peak_distinct = 0;

        function void note_request(logic [mct_pkg::ACTION_W-1:0] action,
                                   logic [mct_pkg::IN_W-1:0] value,
                                   logic [mct_pkg::IN_W-1:0] amount);
            bag_result_t r;
            int slot;
            slot = -1;
            for (int i = 0; i < used_slots; i++)
                if (slot < 0 && slot_value[i] == value) slot = i;
            r.found       = (slot >= 0);
            r.occurrences = (slot >= 0) ? slot_count[slot] : '0;
            r.removed     = '0;
            r.status      = mct_pkg::STATUS_OK;
            if (action == mct_pkg::ACT_ADD) begin
                if (slot >= 0) begin
                    if (slot_count[slot] != mct_pkg::COUNT_MAX) begin
                        slot_count[slot] = slot_count[slot] + 1'b1;
                        if (running_total != mct_pkg::COUNT_MAX)
                            running_total = running_total + 1'b1;
                    end
                    r.occurrences = slot_count[slot];
                end else if (used_slots >= TABLE_DEPTH) begin
                    r.status = mct_pkg::STATUS_FULL;
                    full_drops++;
                end else begin
                    slot_value[used_slots] = value;
                    slot_count[used_slots] = 1;
                    used_slots++;
                    if (running_total != mct_pkg::COUNT_MAX)
                        running_total = running_total + 1'b1;
                    r.occurrences = 1;
                end
            end else if (action == mct_pkg::ACT_REMOVE) begin
                if (amount[mct_pkg::IN_W-1]) begin
                    r.status = mct_pkg::STATUS_NEG;
                    neg_rejects++;
                end else if (slot >= 0) begin
                    if ({1'b0, slot_count[slot]} > amount) begin
                        slot_count[slot] = slot_count[slot] - amount[mct_pkg::COUNT_W-1:0];
                        r.removed = amount[mct_pkg::COUNT_W-1:0];
                        r.occurrences = slot_count[slot];
                    end else begin
                        r.removed = slot_count[slot];
                        for (int i = slot; i < used_slots - 1; i++) begin
                            slot_value[i] = slot_value[i + 1];
                            slot_count[i] = slot_count[i + 1];
                        end
                        used_slots--;
                        r.occurrences = '0;
                        deletions++;
                    end
                    running_total = (running_total > r.removed) ? running_total - r.removed : '0;
                end
            end
            r.total    = running_total;
            r.distinct = DIST_W'(used_slots);
            if (used_slots > peak_distinct) peak_distinct = used_slots;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [mct_pkg::IN_W-1:0] want,
                                    logic [mct_pkg::IN_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(bag_result_t got);
            bag_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result transaction with no request outstanding", $time);
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            compare_field("found", want.found, got.found);
            compare_field("occurrences", want.occurrences, got.occurrences);
            compare_field("removed", want.removed, got.removed);
            compare_field("total", want.total, got.total);
            compare_field("distinct", want.distinct, got.distinct);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic [mct_pkg::ACTION_W-1:0]     s_action;
    logic signed [mct_pkg::IN_W-1:0]  s_value;
    logic signed [mct_pkg::IN_W-1:0]  s_amount;
    logic                             m_valid;
    logic                             m_ready;
    logic                             m_found;
    logic [mct_pkg::COUNT_W-1:0]      m_occurrences;
    logic [mct_pkg::COUNT_W-1:0]      m_removed;
    logic [mct_pkg::COUNT_W-1:0]      m_total;
    logic [DIST_W-1:0]                m_distinct;
    logic [mct_pkg::STATUS_W-1:0]     m_status;

    bag_scoreboard sb = new;
    bag_result_t   seen_result;
    bit            steady = 1'b0;
    int            requests_sent = 0;
    int            quiet_cycles = 0;
    logic [mct_pkg::IN_W-1:0] value_pool [POOL_MAX];
    int            pool_size = 1;

    multiset_count_table #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .VALUE_WIDTH(32)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_value(s_value),
        .s_amount(s_amount),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_found(m_found),
        .m_occurrences(m_occurrences),
        .m_removed(m_removed),
        .m_total(m_total),
        .m_distinct(m_distinct),
        .m_status(m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic send_request(input logic [mct_pkg::ACTION_W-1:0] action,
                                input logic [mct_pkg::IN_W-1:0] value,
                                input logic [mct_pkg::IN_W-1:0] amount);
        if (!steady && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= action;
        s_value  <= value;
        s_amount <= amount;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(action, value, amount);
        requests_sent++;
    endtask

    function automatic logic [mct_pkg::IN_W-1:0] pick_amount();
        int r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(0, 3);
        if (r < 65) return $urandom & 32'h7FFF_FFFF;
        if (r < 75) return 32'h7FFF_FFFF;
        if (r < 88) return $urandom | 32'h8000_0000;
        return $urandom_range(4, 20);
    endfunction

    task automatic refill_pool(input int n);
        pool_size = n;
        for (int i = 0; i < n; i++)
            value_pool[i] = $urandom;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
    endtask

    initial begin
        int     r;
        phase_t kind;
        logic [mct_pkg::ACTION_W-1:0] action;
        logic [mct_pkg::IN_W-1:0]     value;

        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_action <= mct_pkg::ACT_ADD;
        s_value  <= '0;
        s_amount <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extreme values, zero and negative amounts, deletes with shift
        send_request(ACT_QUERY,           32'h0000_0000, 32'h0000_0000);
        send_request(mct_pkg::ACT_REMOVE, 32'h1234_5678, 32'h0000_0005);
        send_request(mct_pkg::ACT_ADD,    32'h8000_0000, 32'hFFFF_FFFF);
        send_request(mct_pkg::ACT_ADD,    32'h7FFF_FFFF, 32'h0000_0000);
        send_request(mct_pkg::ACT_ADD,    32'h7FFF_FFFF, 32'h8000_0000);
        send_request(mct_pkg::ACT_ADD,    32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(mct_pkg::ACT_ADD,    32'h0000_0000, 32'h0000_0000);
        send_request(ACT_QUERY,           32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_SPARE,           32'h7FFF_FFFF, 32'h0000_0001);
        send_request(mct_pkg::ACT_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(mct_pkg::ACT_REMOVE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(mct_pkg::ACT_REMOVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(mct_pkg::ACT_REMOVE, 32'h7FFF_FFFF, 32'h0000_0001);
        send_request(mct_pkg::ACT_REMOVE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ACT_QUERY,           32'hFFFF_FFFF, 32'h0000_0000);
        send_request(mct_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0001);
        send_request(mct_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_request(mct_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0000_0005);
        send_request(ACT_SPARE,           32'h5555_AAAA, 32'h0000_0000);
        send_request(mct_pkg::ACT_REMOVE, 32'hAAAA_5555, 32'h8000_0001);

        kind = PH_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                kind   = phase_t'((n / PHASE_ITEMS) % 3);
                steady = (n / PHASE_ITEMS == 4);
                case (kind)
                    PH_FILL:  refill_pool(POOL_MAX);
                    PH_CHURN: refill_pool(24);
                    default:  refill_pool(48);
                endcase
            end
            r = $urandom_range(99);
            case (kind)
                PH_FILL:  action = (r < 85) ? mct_pkg::ACT_ADD :
                                   (r < 93) ? mct_pkg::ACT_REMOVE :
                                   (r < 97) ? ACT_QUERY : ACT_SPARE;
                PH_CHURN: action = (r < 45) ? mct_pkg::ACT_ADD :
                                   (r < 85) ? mct_pkg::ACT_REMOVE :
                                   (r < 96) ? ACT_QUERY : ACT_SPARE;
                default:  action = (r < 15) ? mct_pkg::ACT_ADD :
                                   (r < 85) ? mct_pkg::ACT_REMOVE :
                                   (r < 96) ? ACT_QUERY : ACT_SPARE;
            endcase
            if ($urandom_range(99) < 5) value = $urandom;
            else value = value_pool[$urandom_range(0, pool_size - 1)];
            send_request(action, value,
                         (action == mct_pkg::ACT_REMOVE) ? pick_amount() : $urandom);
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d requests sent, %0d results checked, up to %0d distinct values held",
                 requests_sent, sb.results_checked, sb.peak_distinct);
        $display("%0d adds dropped on a full table, %0d negative removals, %0d entries deleted",
                 sb.full_drops, sb.neg_rejects, sb.deletions);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= steady || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result.found       = m_found;
            seen_result.occurrences = m_occurrences;
            seen_result.removed     = m_removed;
            seen_result.total       = m_total;
            seen_result.distinct    = m_distinct;
            seen_result.status      = m_status;
            sb.check_result(seen_result);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
